FILE: rtl/phlm_pkg.sv
// Shared types and constants of the peak hold level meter.
package phlm_pkg;

    localparam int LEVEL_W = 12;
    localparam int STEP_W  = 10;
    localparam int AGE_W   = 16;
    localparam int CH_W    = 6;
    localparam int KIND_W  = 3;
    localparam int REG_W   = 2;

    localparam logic [KIND_W-1:0] KIND_PEAK      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR_CLIP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

    localparam logic [REG_W-1:0] REG_SILENCE   = 2'd0;
    localparam logic [REG_W-1:0] REG_RELEASE   = 2'd1;
    localparam logic [REG_W-1:0] REG_HOLD      = 2'd2;
    localparam logic [REG_W-1:0] REG_THRESHOLD = 2'd3;

    localparam logic signed [LEVEL_W-1:0] SILENCE_RESET   = -12'sd1920;
    localparam logic [STEP_W-1:0]         RELEASE_RESET   = 10'd16;
    localparam logic [AGE_W-1:0]          HOLD_RESET      = 16'd60;
    localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET = 12'sd0;
    localparam logic [AGE_W-1:0]          AGE_MAX         = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] silence;
        logic [STEP_W-1:0]         release_step;
        logic [AGE_W-1:0]          hold_ticks;
        logic signed [LEVEL_W-1:0] threshold;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic clear_all;
        logic rd_en;
        logic exec;
        logic next_ch;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic last_ch;
    } t_status;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic signed [LEVEL_W-1:0] hold;
        logic signed [LEVEL_W-1:0] pending;
        logic [AGE_W-1:0]          age;
        logic                      clip;
    } t_entry;

endpackage

FILE: rtl/phlm_regs.sv
// Configuration register bank of the peak hold level meter.
module phlm_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output phlm_pkg::t_cfg       o_cfg
);

    phlm_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence      <= phlm_pkg::SILENCE_RESET;
            r_cfg.release_step <= phlm_pkg::RELEASE_RESET;
            r_cfg.hold_ticks   <= phlm_pkg::HOLD_RESET;
            r_cfg.threshold    <= phlm_pkg::THRESHOLD_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                phlm_pkg::REG_SILENCE:   r_cfg.silence      <= $signed(pwdata[11:0]);
                phlm_pkg::REG_RELEASE:   r_cfg.release_step <= pwdata[9:0];
                phlm_pkg::REG_HOLD:      r_cfg.hold_ticks   <= pwdata[15:0];
                phlm_pkg::REG_THRESHOLD: r_cfg.threshold    <= $signed(pwdata[11:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            phlm_pkg::REG_SILENCE:   prdata = 32'($signed(r_cfg.silence));
            phlm_pkg::REG_RELEASE:   prdata = {22'd0, r_cfg.release_step};
            phlm_pkg::REG_HOLD:      prdata = {16'd0, r_cfg.hold_ticks};
            phlm_pkg::REG_THRESHOLD: prdata = 32'($signed(r_cfg.threshold));
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/phlm_ctrl.sv
// Controller state machine of the peak hold level meter.
module phlm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [phlm_pkg::KIND_W-1:0]       i_kind,
    input  phlm_pkg::t_status                 i_status,
    output phlm_pkg::t_cmd                    o_cmd,
    output logic                              o_busy
);

    phlm_pkg::t_state r_state;
    phlm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phlm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            phlm_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        phlm_pkg::KIND_PEAK,
                        phlm_pkg::KIND_TICK,
                        phlm_pkg::KIND_CLEAR_CLIP,
                        phlm_pkg::KIND_READ: n_state = phlm_pkg::ST_READ;
                        default:             n_state = phlm_pkg::ST_IDLE;
                    endcase
                end
            end
            phlm_pkg::ST_READ: n_state = phlm_pkg::ST_EXEC;
            phlm_pkg::ST_EXEC: begin
                if (i_status.is_tick && !i_status.last_ch) begin
                    n_state = phlm_pkg::ST_READ;
                end else begin
                    n_state = phlm_pkg::ST_IDLE;
                end
            end
            default: n_state = phlm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy            = (r_state != phlm_pkg::ST_IDLE);
        o_cmd.load        = (r_state == phlm_pkg::ST_IDLE) && i_start;
        o_cmd.clear_all   = o_cmd.load && (i_kind == phlm_pkg::KIND_CLEAR_ALL);
        o_cmd.rd_en       = (r_state == phlm_pkg::ST_READ);
        o_cmd.exec        = (r_state == phlm_pkg::ST_EXEC);
        o_cmd.next_ch     = o_cmd.exec && i_status.is_tick && !i_status.last_ch;
    end

    a_read_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phlm_pkg::ST_READ) |=> (r_state == phlm_pkg::ST_EXEC))
        else $error("read cycle not followed by execute");

    a_clear_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear_all |=> (r_state == phlm_pkg::ST_IDLE))
        else $error("clear all left the idle state");

    a_walk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.next_ch |=> (r_state == phlm_pkg::ST_READ))
        else $error("tick walk stopped early");

endmodule

FILE: rtl/phlm_datapath.sv
// Channel memory, tick arithmetic and result registers of the peak hold level meter.
module phlm_datapath #(
    parameter int CHANNELS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  phlm_pkg::t_cmd                          i_cmd,
    input  phlm_pkg::t_cfg                          i_cfg,
    input  logic [phlm_pkg::KIND_W-1:0]             i_kind,
    input  logic [phlm_pkg::CH_W-1:0]               i_channel,
    input  logic signed [phlm_pkg::LEVEL_W-1:0]     i_peak_level,
    output phlm_pkg::t_status                       o_status,
    output logic                                    o_strobe,
    output logic [phlm_pkg::CH_W-1:0]               o_out_channel,
    output logic signed [phlm_pkg::LEVEL_W-1:0]     o_level,
    output logic signed [phlm_pkg::LEVEL_W-1:0]     o_held_peak,
    output logic                                    o_clip_flag,
    output logic                                    o_last
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

    phlm_pkg::t_entry r_mem [0:CHANNELS-1];

    logic [phlm_pkg::KIND_W-1:0]            r_kind;
    logic [phlm_pkg::CH_W-1:0]              r_channel;
    logic signed [phlm_pkg::LEVEL_W-1:0]    r_peak;
    logic                                   r_ch_ok;
    logic [AW-1:0]                          r_ch_cnt;
    logic [CHANNELS-1:0]                    r_valid;
    logic signed [phlm_pkg::LEVEL_W-1:0]    r_clr_sil;
    phlm_pkg::t_entry                       r_rd_data;
    logic                                   r_rd_valid;

    logic                                   r_strobe;
    logic [phlm_pkg::CH_W-1:0]              r_out_channel;
    logic signed [phlm_pkg::LEVEL_W-1:0]    r_level;
    logic signed [phlm_pkg::LEVEL_W-1:0]    r_held_peak;
    logic                                   r_clip_flag;
    logic                                   r_last;

    logic [AW-1:0]                          addr;
    phlm_pkg::t_entry                       cur;
    phlm_pkg::t_entry                       upd;
    logic                                   is_tick;
    logic                                   is_read;
    logic                                   wr_en;
    logic signed [phlm_pkg::LEVEL_W:0]      dec;
    logic signed [phlm_pkg::LEVEL_W:0]      sil_x;
    logic [phlm_pkg::AGE_W-1:0]             age_inc;
    logic signed [phlm_pkg::LEVEL_W-1:0]    tick_level;

    assign is_tick = (r_kind == phlm_pkg::KIND_TICK);
    assign is_read = (r_kind == phlm_pkg::KIND_READ);
    assign addr    = is_tick ? r_ch_cnt : r_channel[AW-1:0];

    assign o_status.is_tick = is_tick;
    assign o_status.last_ch = (r_ch_cnt == LAST_CH);

    // An entry not written since the last clear reads as that clear left it.
    always_comb begin
        if (r_rd_valid) begin
            cur = r_rd_data;
        end else begin
            cur.level   = r_clr_sil;
            cur.hold    = r_clr_sil;
            cur.pending = r_clr_sil;
            cur.age     = '0;
            cur.clip    = 1'b0;
        end
    end

    always_comb begin
        dec     = $signed({cur.level[phlm_pkg::LEVEL_W-1], cur.level})
                  - $signed({3'b000, i_cfg.release_step});
        sil_x   = $signed({i_cfg.silence[phlm_pkg::LEVEL_W-1], i_cfg.silence});
        age_inc = (cur.age != phlm_pkg::AGE_MAX) ? cur.age + 16'd1 : cur.age;
        if (cur.pending > cur.level) begin
            tick_level = cur.pending;
        end else if (dec > sil_x) begin
            tick_level = dec[phlm_pkg::LEVEL_W-1:0];
        end else begin
            tick_level = i_cfg.silence;
        end

        upd   = cur;
        wr_en = 1'b0;
        case (r_kind)
            phlm_pkg::KIND_PEAK: begin
                wr_en = r_ch_ok;
                if (r_peak > cur.pending) begin
                    upd.pending = r_peak;
                end
            end
            phlm_pkg::KIND_CLEAR_CLIP: begin
                wr_en    = r_ch_ok;
                upd.clip = 1'b0;
            end
            phlm_pkg::KIND_TICK: begin
                wr_en     = 1'b1;
                upd.level = tick_level;
                if (cur.pending >= cur.hold) begin
                    upd.hold = cur.pending;
                    upd.age  = '0;
                end else begin
                    upd.age = age_inc;
                    if (age_inc > i_cfg.hold_ticks) begin
                        upd.hold = tick_level;
                    end
                end
                if (cur.pending >= i_cfg.threshold) begin
                    upd.clip = 1'b1;
                end
                upd.pending = i_cfg.silence;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[addr];
        end
        if (i_cmd.exec && wr_en) begin
            r_mem[addr] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_channel <= i_channel;
            r_peak    <= i_peak_level;
            r_ch_ok   <= ({1'b0, i_channel} < 7'(CHANNELS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_cnt   <= '0;
            r_valid    <= '0;
            r_clr_sil  <= phlm_pkg::SILENCE_RESET;
            r_rd_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ch_cnt <= '0;
            end else if (i_cmd.next_ch) begin
                r_ch_cnt <= r_ch_cnt + 1'b1;
            end
            if (i_cmd.clear_all) begin
                r_valid   <= '0;
                r_clr_sil <= i_cfg.silence;
            end else if (i_cmd.exec && wr_en) begin
                r_valid[addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[addr];
            end
            r_strobe <= i_cmd.exec && (is_tick || is_read);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (is_tick) begin
                r_out_channel <= phlm_pkg::CH_W'(r_ch_cnt);
                r_level       <= upd.level;
                r_held_peak   <= upd.hold;
                r_clip_flag   <= upd.clip;
                r_last        <= (r_ch_cnt == LAST_CH);
            end else if (r_ch_ok) begin
                r_out_channel <= r_channel;
                r_level       <= cur.level;
                r_held_peak   <= cur.hold;
                r_clip_flag   <= cur.clip;
                r_last        <= 1'b1;
            end else begin
                r_out_channel <= r_channel;
                r_level       <= i_cfg.silence;
                r_held_peak   <= i_cfg.silence;
                r_clip_flag   <= 1'b0;
                r_last        <= 1'b1;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_channel = r_out_channel;
    assign o_level       = r_level;
    assign o_held_peak   = r_held_peak;
    assign o_clip_flag   = r_clip_flag;
    assign o_last        = r_last;

    a_strobe_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.exec))
        else $error("result strobe without an execute cycle");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |=> !r_strobe)
        else $error("result follows the final result of a run");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ch_cnt} < (AW + 1)'(CHANNELS)))
        else $error("channel counter beyond the last channel");

endmodule

FILE: rtl/peak_hold_level_meter.sv
// Top level of the multi-channel peak hold level meter.
//
// Requests enter on start with kind, channel and peak level, and are taken
// when start is high and busy is low. A peak request, a clip clear and a
// read each keep the block busy through a read and an execute state; a read
// gives its result in the cycle after its execute state. A tick walks every
// channel through a read and an execute state each, stays busy throughout
// and gives one result per channel, the last marked by o_last. A clear-all
// request never leaves idle, and undefined kinds are dropped. The rate is
// set by the single-port channel memory: each channel update is a read
// followed by a write of the entry. Results appear for one cycle with
// o_strobe high; the receiver cannot stall them. The APB port sets silence
// level, release step, hold ticks and clip threshold; the user must write
// it only while the block is idle, which the block itself does not enforce.
// After reset every channel sits at the silence level with zero hold age
// and no clip; valid bits make this immediate, with no clearing pass.
module peak_hold_level_meter #(
    parameter int CHANNELS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [phlm_pkg::KIND_W-1:0]         i_kind,
    input  logic [phlm_pkg::CH_W-1:0]           i_channel,
    input  logic signed [phlm_pkg::LEVEL_W-1:0] i_peak_level,
    output logic                                o_strobe,
    output logic [phlm_pkg::CH_W-1:0]           o_out_channel,
    output logic signed [phlm_pkg::LEVEL_W-1:0] o_level,
    output logic signed [phlm_pkg::LEVEL_W-1:0] o_held_peak,
    output logic                                o_clip_flag,
    output logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    phlm_pkg::t_cfg    cfg;
    phlm_pkg::t_cmd    cmd;
    phlm_pkg::t_status status;

    phlm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    phlm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    phlm_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_kind        (i_kind),
        .i_channel     (i_channel),
        .i_peak_level  (i_peak_level),
        .o_status      (status),
        .o_strobe      (o_strobe),
        .o_out_channel (o_out_channel),
        .o_level       (o_level),
        .o_held_peak   (o_held_peak),
        .o_clip_flag   (o_clip_flag),
        .o_last        (o_last)
    );

endmodule

FILE: sim/peak_hold_level_meter_tb.sv
// Self-checking testbench for the peak hold level meter against predicted readings.
module peak_hold_level_meter_tb;

    localparam int CHANNELS    = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [phlm_pkg::KIND_W-1:0]         kind;
        logic [phlm_pkg::CH_W-1:0]           ch;
        logic signed [phlm_pkg::LEVEL_W-1:0] peak;
    } t_meter_req;

    typedef struct {
        logic [phlm_pkg::CH_W-1:0]           ch;
        logic signed [phlm_pkg::LEVEL_W-1:0] level;
        logic signed [phlm_pkg::LEVEL_W-1:0] held;
        logic                                clip;
        logic                                last;
    } t_meter_reading;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [phlm_pkg::KIND_W-1:0]         i_kind = '0;
    logic [phlm_pkg::CH_W-1:0]           i_channel = '0;
    logic signed [phlm_pkg::LEVEL_W-1:0] i_peak_level = '0;
    logic                                o_strobe;
    logic [phlm_pkg::CH_W-1:0]           o_out_channel;
    logic signed [phlm_pkg::LEVEL_W-1:0] o_level;
    logic signed [phlm_pkg::LEVEL_W-1:0] o_held_peak;
    logic                                o_clip_flag;
    logic                                o_last;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [3:0]                          paddr = '0;
    logic [31:0]                         pwdata = '0;
    logic [31:0]                         prdata;
    logic                                pready;

    // Model of the meter state and its registers.
    logic signed [phlm_pkg::LEVEL_W-1:0] lvl_mem  [CHANNELS];
    logic signed [phlm_pkg::LEVEL_W-1:0] hold_mem [CHANNELS];
    logic signed [phlm_pkg::LEVEL_W-1:0] pend_mem [CHANNELS];
    logic [phlm_pkg::AGE_W-1:0]          age_mem  [CHANNELS];
    logic                                clip_mem [CHANNELS];
    logic signed [phlm_pkg::LEVEL_W-1:0] cfg_silence;
    logic [phlm_pkg::STEP_W-1:0]         cfg_release;
    logic [phlm_pkg::AGE_W-1:0]          cfg_hold;
    logic signed [phlm_pkg::LEVEL_W-1:0] cfg_thresh;

    t_meter_req     request_fifo[$];
    t_meter_reading expected_readings[$];
    t_meter_req     cur_req;
    t_meter_reading want_rd;
    int             idle_left = 0;
    int             idle_pct = 0;
    int             queued_cnt = 0;
    int             accepted_cnt = 0;
    int             tick_cnt = 0;
    int             reading_cnt = 0;
    int             setting_cnt = 0;
    int             fail_cnt = 0;
    int             cycle_cnt = 0;

    peak_hold_level_meter #(
        .CHANNELS(CHANNELS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_channel(i_channel),
        .i_peak_level(i_peak_level),
        .o_strobe(o_strobe),
        .o_out_channel(o_out_channel),
        .o_level(o_level),
        .o_held_peak(o_held_peak),
        .o_clip_flag(o_clip_flag),
        .o_last(o_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_meter();
        int i;
        for (i = 0; i < CHANNELS; i++) begin
            lvl_mem[i]  = cfg_silence;
            hold_mem[i] = cfg_silence;
            pend_mem[i] = cfg_silence;
            age_mem[i]  = '0;
            clip_mem[i] = 1'b0;
        end
    endfunction

    function automatic void meter_apply(t_meter_req r);
        t_meter_reading rd;
        logic signed [phlm_pkg::LEVEL_W-1:0] p;
        int d;
        int i;
        bit ok;
        ok = r.ch < CHANNELS;
        case (r.kind)
            phlm_pkg::KIND_PEAK: begin
                if (ok && r.peak > pend_mem[r.ch])
                    pend_mem[r.ch] = r.peak;
            end
            phlm_pkg::KIND_TICK: begin
                tick_cnt++;
                for (i = 0; i < CHANNELS; i++) begin
                    p = pend_mem[i];
                    if (p > lvl_mem[i]) begin
                        lvl_mem[i] = p;
                    end else begin
                        d = int'(lvl_mem[i]) - int'(cfg_release);
                        lvl_mem[i] = (d > int'(cfg_silence)) ?
                                     d[phlm_pkg::LEVEL_W-1:0] : cfg_silence;
                    end
                    if (p >= hold_mem[i]) begin
                        hold_mem[i] = p;
                        age_mem[i] = '0;
                    end else begin
                        if (age_mem[i] != phlm_pkg::AGE_MAX)
                            age_mem[i]++;
                        if (age_mem[i] > cfg_hold)
                            hold_mem[i] = lvl_mem[i];
                    end
                    if (p >= cfg_thresh)
                        clip_mem[i] = 1'b1;
                    pend_mem[i] = cfg_silence;
                    rd.ch    = phlm_pkg::CH_W'(i);
                    rd.level = lvl_mem[i];
                    rd.held  = hold_mem[i];
                    rd.clip  = clip_mem[i];
                    rd.last  = (i == CHANNELS - 1);
                    expected_readings.push_back(rd);
                end
            end
            phlm_pkg::KIND_CLEAR_CLIP: begin
                if (ok)
                    clip_mem[r.ch] = 1'b0;
            end
            phlm_pkg::KIND_CLEAR_ALL: clear_meter();
            phlm_pkg::KIND_READ: begin
                rd.ch    = r.ch;
                rd.level = ok ? lvl_mem[r.ch] : cfg_silence;
                rd.held  = ok ? hold_mem[r.ch] : cfg_silence;
                rd.clip  = ok ? clip_mem[r.ch] : 1'b0;
                rd.last  = 1'b1;
                expected_readings.push_back(rd);
            end
            default: ;
        endcase
    endfunction

    function automatic t_meter_req mk_req(logic [phlm_pkg::KIND_W-1:0] k, int ch, int pk);
        t_meter_req r;
        r.kind = k;
        r.ch   = phlm_pkg::CH_W'(ch);
        r.peak = phlm_pkg::LEVEL_W'(pk);
        return r;
    endfunction

    function automatic t_meter_req random_request();
        t_meter_req r;
        int sel;
        sel    = $urandom_range(0, 99);
        r.ch   = phlm_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
        r.peak = phlm_pkg::LEVEL_W'($urandom_range(0, 3071) - 2048);
        if (sel < 62) begin
            r.kind = phlm_pkg::KIND_PEAK;
        end else if (sel < 74) begin
            r.kind = phlm_pkg::KIND_TICK;
        end else if (sel < 82) begin
            r.kind = phlm_pkg::KIND_READ;
        end else if (sel < 88) begin
            r.kind = phlm_pkg::KIND_CLEAR_CLIP;
        end else if (sel < 90) begin
            r.kind = phlm_pkg::KIND_CLEAR_ALL;
        end else if (sel < 96) begin
            r.kind = sel[0] ? phlm_pkg::KIND_PEAK :
                     (sel[1] ? phlm_pkg::KIND_READ : phlm_pkg::KIND_CLEAR_CLIP);
            r.ch   = phlm_pkg::CH_W'($urandom_range(CHANNELS, 63));
        end else begin
            r.kind = phlm_pkg::KIND_W'($urandom_range(phlm_pkg::KIND_READ + 1,
                                                      {phlm_pkg::KIND_W{1'b1}}));
        end
        return r;
    endfunction

    function automatic void queue_request(t_meter_req r);
        request_fifo.push_back(r);
        queued_cnt++;
    endfunction

    task automatic apb_write(logic [phlm_pkg::REG_W-1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            phlm_pkg::REG_SILENCE:   cfg_silence = data[phlm_pkg::LEVEL_W-1:0];
            phlm_pkg::REG_RELEASE:   cfg_release = data[phlm_pkg::STEP_W-1:0];
            phlm_pkg::REG_HOLD:      cfg_hold    = data[phlm_pkg::AGE_W-1:0];
            phlm_pkg::REG_THRESHOLD: cfg_thresh  = data[phlm_pkg::LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_meter_config(logic signed [phlm_pkg::LEVEL_W-1:0] silence,
                                    logic [phlm_pkg::STEP_W-1:0] rel,
                                    logic [phlm_pkg::AGE_W-1:0] hold,
                                    logic signed [phlm_pkg::LEVEL_W-1:0] thresh);
        apb_write(phlm_pkg::REG_SILENCE,
                  {{(32 - phlm_pkg::LEVEL_W){silence[phlm_pkg::LEVEL_W-1]}}, silence});
        apb_write(phlm_pkg::REG_RELEASE, 32'(rel));
        apb_write(phlm_pkg::REG_HOLD, 32'(hold));
        apb_write(phlm_pkg::REG_THRESHOLD,
                  {{(32 - phlm_pkg::LEVEL_W){thresh[phlm_pkg::LEVEL_W-1]}}, thresh});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        setting_cnt++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (accepted_cnt != queued_cnt || busy || expected_readings.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic signed [phlm_pkg::LEVEL_W:0] want,
                               logic signed [phlm_pkg::LEVEL_W:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else if (!start || !busy) begin
            if (start) begin
                meter_apply(cur_req);
                accepted_cnt++;
            end
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (request_fifo.size() != 0 && $urandom_range(1, 100) <= idle_pct) begin
                idle_left = $urandom_range(0, 17);
                start <= 1'b0;
            end else if (request_fifo.size() != 0) begin
                cur_req = request_fifo.pop_front();
                start        <= 1'b1;
                i_kind       <= cur_req.kind;
                i_channel    <= cur_req.ch;
                i_peak_level <= cur_req.peak;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            reading_cnt++;
            if (expected_readings.size() == 0) begin
                $error("unexpected reading for channel %0d", o_out_channel);
                fail_cnt++;
            end else begin
                want_rd = expected_readings.pop_front();
                check_field("out_channel", want_rd.ch, o_out_channel);
                check_field("level", want_rd.level, o_level);
                check_field("held_peak", want_rd.held, o_held_peak);
                check_field("clip_flag", want_rd.clip, o_clip_flag);
                check_field("last", want_rd.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int phase;
        int n;
        cfg_silence = phlm_pkg::SILENCE_RESET;
        cfg_release = phlm_pkg::RELEASE_RESET;
        cfg_hold    = phlm_pkg::HOLD_RESET;
        cfg_thresh  = phlm_pkg::THRESHOLD_RESET;
        clear_meter();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 25;
        queue_request(mk_req(phlm_pkg::KIND_PEAK, 0, 1023));
        queue_request(mk_req(phlm_pkg::KIND_PEAK, 15, -2048));
        queue_request(mk_req(phlm_pkg::KIND_PEAK, 1, 0));
        queue_request(mk_req(phlm_pkg::KIND_PEAK, 2, -1));
        queue_request(mk_req(phlm_pkg::KIND_PEAK, CHANNELS, 1023));
        queue_request(mk_req(phlm_pkg::KIND_PEAK, 63, 1023));
        queue_request(mk_req(phlm_pkg::KIND_TICK, 0, 0));
        queue_request(mk_req(phlm_pkg::KIND_READ, 0, 0));
        queue_request(mk_req(phlm_pkg::KIND_READ, CHANNELS - 1, 0));
        queue_request(mk_req(phlm_pkg::KIND_READ, CHANNELS, 0));
        queue_request(mk_req(phlm_pkg::KIND_READ, 63, -1));
        queue_request(mk_req(phlm_pkg::KIND_CLEAR_CLIP, 0, 0));
        queue_request(mk_req(phlm_pkg::KIND_CLEAR_CLIP, 63, 0));
        queue_request(mk_req(phlm_pkg::KIND_READ, 0, 0));
        queue_request(mk_req(phlm_pkg::KIND_W'(phlm_pkg::KIND_READ + 1), 3, 1023));
        queue_request(mk_req(phlm_pkg::KIND_W'(phlm_pkg::KIND_READ + 2), 0, -2048));
        queue_request(mk_req(phlm_pkg::KIND_W'(phlm_pkg::KIND_READ + 3), 63, -1));
        queue_request(mk_req(phlm_pkg::KIND_TICK, 63, -1));
        queue_request(mk_req(phlm_pkg::KIND_PEAK, 3, -1920));
        queue_request(mk_req(phlm_pkg::KIND_TICK, 0, 0));
        queue_request(mk_req(phlm_pkg::KIND_CLEAR_ALL, 0, 0));
        queue_request(mk_req(phlm_pkg::KIND_READ, 1, 0));
        queue_request(mk_req(phlm_pkg::KIND_TICK, 0, 0));
        wait_drained();

        for (phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: set_meter_config(-12'sd2048, 10'd1023, 16'd0, -12'sd2048);
                2: set_meter_config(12'sd0, 10'd0, 16'hFFFF, 12'sd1023);
                3: set_meter_config(phlm_pkg::LEVEL_W'(-$urandom_range(0, 2048)),
                                    phlm_pkg::STEP_W'($urandom_range(0, 64)),
                                    phlm_pkg::AGE_W'($urandom_range(0, 4)),
                                    phlm_pkg::LEVEL_W'($urandom_range(0, 3071) - 2048));
                4: set_meter_config(phlm_pkg::LEVEL_W'(-$urandom_range(0, 2048)),
                                    phlm_pkg::STEP_W'($urandom_range(0, 1023)),
                                    phlm_pkg::AGE_W'($urandom_range(0, 8)),
                                    phlm_pkg::LEVEL_W'($urandom_range(0, 3071) - 2048));
                default: set_meter_config(phlm_pkg::SILENCE_RESET, phlm_pkg::RELEASE_RESET,
                                          16'd2, phlm_pkg::THRESHOLD_RESET);
            endcase
            idle_pct = (phase == 2 || phase == 5) ? 0 : $urandom_range(10, 40);
            for (n = 0; n < 42; n++)
                queue_request(random_request());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Sent %0d requests (%0d ticks) across %0d register settings.",
                 accepted_cnt, tick_cnt, setting_cnt);
        $display("Compared %0d meter readings; %0d mismatches.", reading_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
